// ===== sv/dtwsl_pkg.sv =====
package dtwsl_pkg;

   localparam int WORD_BITS    = 32;
   localparam int CONTROL_BITS = 8;
   localparam int EVENTS       = WORD_BITS + CONTROL_BITS + 1;
   localparam int CNT_W        = $clog2(EVENTS);
   localparam int BIT_W        = $clog2(WORD_BITS);

   localparam int FREQ_W   = 32;
   localparam int REF_W    = 28;
   localparam int CORR_W   = 24;
   localparam int FACTOR_W = 25;
   localparam int E_W      = REF_W + FACTOR_W;
   localparam int R_W      = E_W + 1;
   localparam int FRAC_W   = 24;

   localparam int Q_DEPTH = 2;
   localparam int QPTR_W  = $clog2(Q_DEPTH);
   localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

   localparam logic REG_REF_CLOCK  = 1'b0;
   localparam logic REG_CLOCK_CORR = 1'b1;

   typedef enum logic [2:0] {
      FS_IDLE,
      FS_MUL,
      FS_CLAMP,
      FS_CHECK,
      FS_DIV,
      FS_PUSH
   } front_state_type;

   typedef struct packed {
      logic                 valid;
      logic [WORD_BITS-1:0] word;
   } q_push_type;

   typedef struct packed {
      logic                 empty;
      logic                 full;
      logic [WORD_BITS-1:0] head;
   } q_status_type;

endpackage

// ===== sv/dtwsl_front.sv =====
module dtwsl_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [dtwsl_pkg::FREQ_W-1:0]   req_freq_hz,
   input  logic                           csr_wr_en,
   input  logic                           csr_index,
   input  logic [dtwsl_pkg::REF_W-1:0]    csr_wdata,
   input  logic                           q_full,
   output dtwsl_pkg::q_push_type          q_push
);

   dtwsl_pkg::front_state_type state_ff, state_in;

   logic                              hold_valid_ff, hold_valid_in;
   logic [dtwsl_pkg::FREQ_W-1:0]      hold_freq_ff, hold_freq_in;
   logic [dtwsl_pkg::FREQ_W-1:0]      freq_ff, freq_in;
   logic [dtwsl_pkg::REF_W-1:0]       ref_clock_ff, ref_clock_in;
   logic [dtwsl_pkg::CORR_W-1:0]      corr_ff, corr_in;
   logic [dtwsl_pkg::E_W-1:0]         e_ff, e_in;
   logic [dtwsl_pkg::R_W-1:0]         r_ff, r_in;
   logic [dtwsl_pkg::WORD_BITS-1:0]   q_ff, q_in;
   logic [dtwsl_pkg::BIT_W-1:0]       bit_ff, bit_in;

   logic signed [dtwsl_pkg::FACTOR_W:0] factor_s;
   logic [dtwsl_pkg::FACTOR_W-1:0]      factor;
   logic [dtwsl_pkg::E_W-1:0]           product;
   logic [dtwsl_pkg::FREQ_W+dtwsl_pkg::FRAC_W-1:0] scaled;
   logic [dtwsl_pkg::R_W-1:0]           r_shift;
   logic [dtwsl_pkg::R_W-1:0]           e_ext;

   assign req_full = hold_valid_ff;

   // effective clock in units of 2^-24 Hz
   assign factor_s = (dtwsl_pkg::FACTOR_W+1)'(1 << dtwsl_pkg::FRAC_W)
                     - {{2{corr_ff[dtwsl_pkg::CORR_W-1]}}, corr_ff};
   assign factor   = factor_s[dtwsl_pkg::FACTOR_W-1:0];
   assign product  = dtwsl_pkg::E_W'(ref_clock_ff) * dtwsl_pkg::E_W'(factor);
   assign scaled   = {freq_ff, {dtwsl_pkg::FRAC_W{1'b0}}};
   assign r_shift  = {r_ff[dtwsl_pkg::R_W-2:0], 1'b0};
   assign e_ext    = {1'b0, e_ff};

   always_comb begin
      state_in      = state_ff;
      hold_valid_in = hold_valid_ff;
      hold_freq_in  = hold_freq_ff;
      freq_in       = freq_ff;
      ref_clock_in  = ref_clock_ff;
      corr_in       = corr_ff;
      e_in          = e_ff;
      r_in          = r_ff;
      q_in          = q_ff;
      bit_in        = bit_ff;
      q_push.valid  = 1'b0;
      q_push.word   = q_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            dtwsl_pkg::REG_REF_CLOCK:  ref_clock_in = csr_wdata;
            dtwsl_pkg::REG_CLOCK_CORR: corr_in = csr_wdata[dtwsl_pkg::CORR_W-1:0];
            default: ;
         endcase
      end

      if (req_push && !hold_valid_ff) begin
         hold_valid_in = 1'b1;
         hold_freq_in  = req_freq_hz;
      end

      unique case (state_ff)
         dtwsl_pkg::FS_IDLE: begin
            if (hold_valid_ff) begin
               freq_in       = hold_freq_ff;
               hold_valid_in = 1'b0;
               state_in      = dtwsl_pkg::FS_MUL;
            end
         end
         dtwsl_pkg::FS_MUL: begin
            e_in     = product;
            state_in = dtwsl_pkg::FS_CLAMP;
         end
         dtwsl_pkg::FS_CLAMP: begin
            if (e_ff < dtwsl_pkg::E_W'(1 << dtwsl_pkg::FRAC_W)) begin
               e_in = dtwsl_pkg::E_W'(1 << dtwsl_pkg::FRAC_W);
            end
            state_in = dtwsl_pkg::FS_CHECK;
         end
         dtwsl_pkg::FS_CHECK: begin
            if (scaled >= (dtwsl_pkg::FREQ_W+dtwsl_pkg::FRAC_W)'(e_ff)) begin
               q_in     = '1;
               state_in = dtwsl_pkg::FS_PUSH;
            end else begin
               r_in     = scaled[dtwsl_pkg::R_W-1:0];
               q_in     = '0;
               bit_in   = '0;
               state_in = dtwsl_pkg::FS_DIV;
            end
         end
         dtwsl_pkg::FS_DIV: begin
            if (r_shift >= e_ext) begin
               r_in = r_shift - e_ext;
               q_in = {q_ff[dtwsl_pkg::WORD_BITS-2:0], 1'b1};
            end else begin
               r_in = r_shift;
               q_in = {q_ff[dtwsl_pkg::WORD_BITS-2:0], 1'b0};
            end
            bit_in = bit_ff + 1'b1;
            if (bit_ff == dtwsl_pkg::BIT_W'(dtwsl_pkg::WORD_BITS - 1)) begin
               state_in = dtwsl_pkg::FS_PUSH;
            end
         end
         dtwsl_pkg::FS_PUSH: begin
            if (!q_full) begin
               q_push.valid = 1'b1;
               state_in     = dtwsl_pkg::FS_IDLE;
            end
         end
         default: state_in = dtwsl_pkg::FS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dtwsl_pkg::FS_IDLE;
         hold_valid_ff <= 1'b0;
         ref_clock_ff  <= dtwsl_pkg::REF_W'(125000000);
         corr_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         hold_valid_ff <= hold_valid_in;
         ref_clock_ff  <= ref_clock_in;
         corr_ff       <= corr_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_freq_ff <= hold_freq_in;
      freq_ff      <= freq_in;
      e_ff         <= e_in;
      r_ff         <= r_in;
      q_ff         <= q_in;
      bit_ff       <= bit_in;
   end

endmodule

// ===== sv/dtwsl_fifo.sv =====
module dtwsl_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  dtwsl_pkg::q_push_type    q_push,
   input  logic                     q_pop,
   output dtwsl_pkg::q_status_type  q_status
);

   logic [dtwsl_pkg::WORD_BITS-1:0] mem_ff [dtwsl_pkg::Q_DEPTH];
   logic [dtwsl_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [dtwsl_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [dtwsl_pkg::QCNT_W-1:0]    count_ff, count_in;
   logic                            do_push, do_pop;

   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == dtwsl_pkg::QCNT_W'(dtwsl_pkg::Q_DEPTH));
   assign q_status.head  = mem_ff[rd_ptr_ff];

   assign do_push = q_push.valid && !q_status.full;
   assign do_pop  = q_pop && !q_status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == dtwsl_pkg::QPTR_W'(dtwsl_pkg::Q_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == dtwsl_pkg::QPTR_W'(dtwsl_pkg::Q_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= q_push.word;
      end
   end

endmodule

// ===== sv/dtwsl_back.sv =====
module dtwsl_back (
   input  logic                            clock,
   input  logic                            reset,
   input  dtwsl_pkg::q_status_type         q_status,
   output logic                            q_pop,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic                            rsp_pin_data,
   output logic                            rsp_pulse_kind,
   output logic [dtwsl_pkg::WORD_BITS-1:0] rsp_tuning_word,
   output logic                            rsp_last
);

   localparam logic [dtwsl_pkg::CNT_W-1:0] LAST_IDX = dtwsl_pkg::CNT_W'(dtwsl_pkg::EVENTS - 1);

   logic                            busy_ff, busy_in;
   logic [dtwsl_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [dtwsl_pkg::WORD_BITS-1:0] word_ff, word_in;
   logic                            out_valid_ff, out_valid_in;
   logic                            out_data_ff, out_data_in;
   logic                            out_kind_ff, out_kind_in;
   logic [dtwsl_pkg::WORD_BITS-1:0] out_word_ff, out_word_in;
   logic                            out_last_ff, out_last_in;

   logic                            advance;
   logic [dtwsl_pkg::CNT_W-1:0]     idx;
   logic [dtwsl_pkg::WORD_BITS-1:0] cur_word;

   assign rsp_empty       = !out_valid_ff;
   assign rsp_pin_data    = out_data_ff;
   assign rsp_pulse_kind  = out_kind_ff;
   assign rsp_tuning_word = out_word_ff;
   assign rsp_last        = out_last_ff;

   assign advance  = !out_valid_ff || rsp_pop;
   assign idx      = busy_ff ? cnt_ff : '0;
   assign cur_word = busy_ff ? word_ff : q_status.head;

   always_comb begin
      busy_in      = busy_ff;
      cnt_in       = cnt_ff;
      word_in      = word_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_kind_in  = out_kind_ff;
      out_word_in  = out_word_ff;
      out_last_in  = out_last_ff;
      q_pop        = 1'b0;

      if (advance) begin
         if (busy_ff || !q_status.empty) begin
            // one frame event per cycle while rsp_ is not stalled: data bits, control bits, load strobe
            out_valid_in = 1'b1;
            out_word_in  = cur_word;
            out_data_in  = (idx < dtwsl_pkg::CNT_W'(dtwsl_pkg::WORD_BITS))
                           ? cur_word[idx[dtwsl_pkg::BIT_W-1:0]] : 1'b0;
            out_kind_in  = (idx == LAST_IDX);
            out_last_in  = (idx == LAST_IDX);
            if (busy_ff) begin
               if (cnt_ff == LAST_IDX) begin
                  busy_in = 1'b0;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end else begin
               q_pop   = 1'b1;
               word_in = q_status.head;
               busy_in = 1'b1;
               cnt_in  = dtwsl_pkg::CNT_W'(1);
            end
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      word_ff     <= word_in;
      out_data_ff <= out_data_in;
      out_kind_ff <= out_kind_in;
      out_word_ff <= out_word_in;
      out_last_ff <= out_last_in;
   end

endmodule

// ===== sv/dds_tuning_word_serial_loader_unit.sv =====
// channel   direction  handshake        payload
// req_      in         push / full      freq_hz
// rsp_      out        pop / empty      pin_data, pulse_kind, tuning_word, last
// csr_      in         wr_en            index, wdata
//
// the front takes a word through multiply, clamp, compare, then a one-bit-per-cycle
// restoring divide of 32 steps; on overflow the compare sets all ones and skips the divide
// the back shifts out 41 events per word, one per cycle unless rsp_ stalls, which sets the rate
// a two-entry queue between them and an input holding register keep both busy
// synchronous active-high reset; no clearing pass
// a stall on rsp_ holds the output register and backs up through the queue
module dds_tuning_word_serial_loader_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [dtwsl_pkg::FREQ_W-1:0]    req_freq_hz,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic                            rsp_pin_data,
   output logic                            rsp_pulse_kind,
   output logic [dtwsl_pkg::WORD_BITS-1:0] rsp_tuning_word,
   output logic                            rsp_last,
   input  logic                            csr_wr_en,
   input  logic                            csr_index,
   input  logic [dtwsl_pkg::REF_W-1:0]     csr_wdata
);

   dtwsl_pkg::q_push_type   q_push;
   dtwsl_pkg::q_status_type q_status;
   logic                    q_pop;

   dtwsl_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_freq_hz (req_freq_hz),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .q_full      (q_status.full),
      .q_push      (q_push)
   );

   dtwsl_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .q_pop    (q_pop),
      .q_status (q_status)
   );

   dtwsl_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_pin_data    (rsp_pin_data),
      .rsp_pulse_kind  (rsp_pulse_kind),
      .rsp_tuning_word (rsp_tuning_word),
      .rsp_last        (rsp_last)
   );

endmodule
